### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands for the session table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define SESS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SESS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SESS_ASSERT(lbl, clk, rst, prop, msg)
`define SESS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

### sv/sess_pkg.sv
// ----------------------------------------------------------------------------
// Session table package
// Command and status codes, entry layout and reset constants.
// ----------------------------------------------------------------------------
`default_nettype none

package sess_pkg;

  localparam logic [1:0] CMD_CREATE   = 2'd0;
  localparam logic [1:0] CMD_VALIDATE = 2'd1;
  localparam logic [1:0] CMD_DESTROY  = 2'd2;
  localparam logic [1:0] CMD_CHECK    = 2'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NO_FREE   = 2'd1;
  localparam logic [1:0] STATUS_EXPIRED   = 2'd2;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

  localparam logic [31:0] LIFETIME_RESET = 32'd3600;

  typedef struct packed {
    logic [31:0] sess_id;
    logic [2:0]  level;
    logic [31:0] created;
    logic [31:0] expires;
    logic [63:0] client_tag;
  } entry_t;

endpackage

`default_nettype wire

### sv/session_table_with_expiry_top.sv
// Create: writes the lowest free slot; with none free and a nonzero client tag,
//   two free scans and one eviction pass that frees slots with that tag.
// Validate, check: find the matching slot, then test expiry; destroy frees the
//   matching slot. A full scan without a match reports not found.
// One item at a time; next input beat taken the cycle after the result beat.
// Reset (rst, synchronous): all slots inactive, lifetime 3600; no clearing pass.
// ----------------------------------------------------------------------------
// Session table with expiry
// Fixed slot table with create, validate, destroy and check permission,
// scanned one slot per cycle under a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module session_table_with_expiry_top
  import sess_pkg::*;
#(
  parameter int SLOT_COUNT = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] sess_id,
  input  wire logic [63:0] client_tag,
  input  wire logic [2:0]  grant_level,
  input  wire logic [2:0]  required_level,
  input  wire logic [31:0] now_seconds,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic             granted,
  output logic [31:0]      entry_session_id,
  output logic [2:0]       entry_level,
  output logic [31:0]      entry_created,
  output logic [31:0]      entry_expires,
  output logic [63:0]      entry_client_tag,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam logic [CW-1:0] CNT_END  = CW'(SLOT_COUNT);
  localparam logic [CW-1:0] CNT_LAST = CW'(SLOT_COUNT - 1);
  localparam logic [IW-1:0] IDX_LAST = IW'(SLOT_COUNT - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FREE   = 3'd1;
  localparam logic [2:0] S_EVICT  = 3'd2;
  localparam logic [2:0] S_MATCH  = 3'd3;
  localparam logic [2:0] S_EXPIRE = 3'd4;
  localparam logic [2:0] S_WRITE  = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0]            state;
  logic [2:0]            state_next;
  logic [CW-1:0]         cnt;
  logic [IW-1:0]         rd_idx;
  logic                  rd_vld;
  logic                  evicted;
  logic [IW-1:0]         slot_sel;
  logic [SLOT_COUNT-1:0] active;
  logic [31:0]           lifetime;

  logic [1:0]  cmd_q;
  logic [31:0] sid_q;
  logic [63:0] tag_q;
  logic [2:0]  grant_q;
  logic [2:0]  req_q;
  logic [31:0] now_q;
  entry_t      ent_q;

  entry_t mem [SLOT_COUNT];
  entry_t rd_data;
  entry_t wr_data;

  logic in_beat;
  logic out_beat;
  logic issue;
  logic free_hit;
  logic match_hit;
  logic is_expired;

  assign in_ready   = (state == S_IDLE);
  assign out_valid  = (state == S_OUT);
  assign in_beat    = in_valid && in_ready;
  assign out_beat   = out_valid && out_ready;
  assign issue      = ((state == S_EVICT) || (state == S_MATCH)) && (cnt < CNT_END);
  assign free_hit   = !active[cnt[IW-1:0]];
  assign match_hit  = rd_vld && active[rd_idx] && (rd_data.sess_id == sid_q);
  assign is_expired = now_q > ent_q.expires;

  assign wr_data = {sid_q, grant_q, now_q, now_q + lifetime, tag_q};

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_beat) begin
          state_next = (cmd == CMD_CREATE) ? S_FREE : S_MATCH;
        end
      end
      S_FREE: begin
        if (free_hit) begin
          state_next = S_WRITE;
        end else if (cnt == CNT_LAST) begin
          state_next = (!evicted && (tag_q != 64'd0)) ? S_EVICT : S_OUT;
        end
      end
      S_EVICT: begin
        if (rd_vld && (rd_idx == IDX_LAST)) begin
          state_next = S_FREE;
        end
      end
      S_MATCH: begin
        if (match_hit) begin
          state_next = (cmd_q == CMD_DESTROY) ? S_OUT : S_EXPIRE;
        end else if (rd_vld && (rd_idx == IDX_LAST)) begin
          state_next = S_OUT;
        end
      end
      S_EXPIRE: state_next = S_OUT;
      S_WRITE:  state_next = S_OUT;
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      rd_vld   <= 1'b0;
      evicted  <= 1'b0;
      active   <= '0;
      lifetime <= LIFETIME_RESET;
    end else begin
      state  <= state_next;
      rd_vld <= issue;
      if (cfg_wr_en) begin
        lifetime <= cfg_wr_data;
      end
      case (state)
        S_IDLE: begin
          cnt     <= '0;
          evicted <= 1'b0;
        end
        S_FREE: begin
          if (!free_hit) begin
            cnt <= (cnt == CNT_LAST) ? '0 : cnt + 1'b1;
          end
        end
        S_EVICT: begin
          if (issue) begin
            cnt <= cnt + 1'b1;
          end
          if (rd_vld && active[rd_idx] && (rd_data.client_tag == tag_q)) begin
            active[rd_idx] <= 1'b0;
          end
          if (rd_vld && (rd_idx == IDX_LAST)) begin
            cnt     <= '0;
            evicted <= 1'b1;
          end
        end
        S_MATCH: begin
          if (issue) begin
            cnt <= cnt + 1'b1;
          end
          if (match_hit && (cmd_q == CMD_DESTROY)) begin
            active[rd_idx] <= 1'b0;
          end
        end
        S_EXPIRE: begin
          if (is_expired) begin
            active[slot_sel] <= 1'b0;
          end
        end
        S_WRITE: active[slot_sel] <= 1'b1;
        default: ;
      endcase
    end
  end

  // slot memory
  always_ff @(posedge clk) begin
    rd_data <= mem[cnt[IW-1:0]];
    rd_idx  <= cnt[IW-1:0];
    if (state == S_WRITE) begin
      mem[slot_sel] <= wr_data;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_beat) begin
      cmd_q   <= cmd;
      sid_q   <= sess_id;
      tag_q   <= client_tag;
      grant_q <= grant_level;
      req_q   <= required_level;
      now_q   <= now_seconds;
    end
    case (state)
      S_FREE: begin
        slot_sel <= cnt[IW-1:0];
        if (!free_hit && (cnt == CNT_LAST) && (evicted || (tag_q == 64'd0))) begin
          status           <= STATUS_NO_FREE;
          granted          <= 1'b0;
          entry_session_id <= '0;
          entry_level      <= '0;
          entry_created    <= '0;
          entry_expires    <= '0;
          entry_client_tag <= '0;
        end
      end
      S_MATCH: begin
        slot_sel <= rd_idx;
        ent_q    <= rd_data;
        if (match_hit || (rd_vld && (rd_idx == IDX_LAST))) begin
          status           <= match_hit ? STATUS_OK : STATUS_NOT_FOUND;
          granted          <= 1'b0;
          entry_session_id <= '0;
          entry_level      <= '0;
          entry_created    <= '0;
          entry_expires    <= '0;
          entry_client_tag <= '0;
        end
      end
      S_EXPIRE: begin
        if (is_expired) begin
          status <= STATUS_EXPIRED;
        end else begin
          status           <= STATUS_OK;
          granted          <= (cmd_q == CMD_CHECK) && (ent_q.level >= req_q);
          entry_session_id <= ent_q.sess_id;
          entry_level      <= ent_q.level;
          entry_created    <= ent_q.created;
          entry_expires    <= ent_q.expires;
          entry_client_tag <= ent_q.client_tag;
        end
      end
      S_WRITE: begin
        status           <= STATUS_OK;
        granted          <= 1'b0;
        entry_session_id <= wr_data.sess_id;
        entry_level      <= wr_data.level;
        entry_created    <= wr_data.created;
        entry_expires    <= wr_data.expires;
        entry_client_tag <= wr_data.client_tag;
      end
      default: ;
    endcase
  end

  `SESS_ASSERT(a_no_overlap, clk, rst, !(in_ready && out_valid), "input taken while result pending")
  `SESS_ASSERT_NEXT(a_busy_after_in, clk, rst, in_beat, !in_ready, "ready held after input beat")
  `SESS_ASSERT_NEXT(a_idle_after_out, clk, rst, out_beat, in_ready, "not idle after result beat")
  `SESS_ASSERT(a_fail_zero, clk, rst,
    !(out_valid && (status != STATUS_OK)) ||
    (!granted && (entry_session_id == 32'd0) && (entry_client_tag == 64'd0)),
    "failed result carries entry data")
  `SESS_ASSERT(a_grant_ok, clk, rst, !(out_valid && granted) || (status == STATUS_OK),
    "granted without ok status")

endmodule

`default_nettype wire
